FILE: design/assert_macros.svh
// Shared assertion shorthands, clocked on i_clk and quiet while i_rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define FPML_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define FPML_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: design/fpml_pkg.sv
package fpml_pkg;

    localparam int DEF_MAX_ROW_LEN = 1024;
    localparam int DEF_MAX_ROWS    = 1024;
    localparam int ROW_LEN_RESET   = 1024;
    localparam int ROW_CNT_RESET   = 1024;
    localparam int MIN_DIM         = 3;

    localparam int CFG_W      = 11;
    localparam int CFG_IDX_W  = 1;
    localparam int Q_W        = 32;
    localparam int FRAC_W     = 16;
    localparam int QUO_W      = Q_W + FRAC_W;
    localparam int NUM_FIELDS = 8;
    localparam int CELL_W     = Q_W * NUM_FIELDS;
    localparam int NUM_FACES  = 4;
    localparam int NUM_OPS    = 4;
    localparam int POS_W      = 10;
    localparam int OUT_DATA_W = 56;

    // field slots inside one cell word
    localparam int F_VAL  = 0;
    localparam int F_COEF = 1;
    localparam int F_JAC  = 2;
    localparam int F_G11  = 3;
    localparam int F_G22  = 4;
    localparam int F_G23  = 5;
    localparam int F_DX   = 6;
    localparam int F_DY   = 7;

    // faces: the two x faces first, then the two y faces
    localparam int FACE_RIGHT = 0;
    localparam int FACE_LEFT  = 1;
    localparam int FACE_DOWN  = 2;
    localparam int FACE_UP    = 3;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ROW_LENGTH = 1'b0,
        REG_ROW_COUNT  = 1'b1
    } t_reg_idx;

    typedef logic signed [Q_W-1:0] t_q;

    localparam t_q Q_MAX = 32'sh7FFF_FFFF;
    localparam t_q Q_MIN = 32'sh8000_0000;
    localparam t_q Q_ONE = 32'sh0001_0000;

    localparam logic [QUO_W-1:0] QUO_POS_LIM = {{FRAC_W{1'b0}}, 1'b0, {(Q_W-1){1'b1}}};
    localparam logic [QUO_W-1:0] QUO_NEG_LIM = {{FRAC_W{1'b0}}, 1'b1, {(Q_W-1){1'b0}}};

    // operands of the numerator and denominator product chains of one face
    typedef struct packed {
        logic [NUM_OPS-1:0][Q_W-1:0] nop;
        logic [NUM_OPS-1:0][Q_W-1:0] dop;
        logic [Q_W-1:0]              diff;
    } t_ops;

    // one step of the restoring divider
    typedef struct packed {
        logic [Q_W-1:0]   rem;
        logic [QUO_W-1:0] sh;
        logic [Q_W-1:0]   dmag;
        logic             neg;
        logic             fault;
        logic [Q_W-1:0]   diff;
    } t_div;

    typedef struct packed {
        logic [POS_W-1:0] row;
        logic [POS_W-1:0] col;
        logic             last;
    } t_pos;

    typedef struct packed {
        t_q   lap;
        t_pos pos;
        logic fault;
    } t_res;

    function automatic t_q cell_field(input logic [CELL_W-1:0] c, input int idx);
        return t_q'(c[idx*Q_W +: Q_W]);
    endfunction

    function automatic t_q avg_q(input t_q a, input t_q b);
        logic signed [Q_W:0] s;
        s = {a[Q_W-1], a} + {b[Q_W-1], b};
        return t_q'(s[Q_W:1]);
    endfunction

    function automatic t_q diff_q(input t_q a, input t_q b);
        logic signed [Q_W:0] s;
        s = {a[Q_W-1], a} - {b[Q_W-1], b};
        if (s[Q_W] != s[Q_W-1]) begin
            return s[Q_W] ? Q_MIN : Q_MAX;
        end
        return t_q'(s[Q_W-1:0]);
    endfunction

    function automatic t_q neg_q(input t_q a);
        return (a == Q_MIN) ? Q_MAX : t_q'(-a);
    endfunction

    // floor(a*b / 2^16), saturated
    function automatic t_q mul_q(input t_q a, input t_q b);
        logic signed [2*Q_W-1:0] p;
        logic [Q_W-FRAC_W:0]     top;
        p   = a * b;
        top = p[2*Q_W-1 : Q_W+FRAC_W-1];
        if (top == '0 || top == '1) begin
            return t_q'(p[Q_W+FRAC_W-1 : FRAC_W]);
        end
        return p[2*Q_W-1] ? Q_MIN : Q_MAX;
    endfunction

    function automatic t_q sum4_q(input t_q a, input t_q b, input t_q c, input t_q d);
        logic signed [Q_W+1:0] s;
        s = {{2{a[Q_W-1]}}, a} + {{2{b[Q_W-1]}}, b}
          + {{2{c[Q_W-1]}}, c} + {{2{d[Q_W-1]}}, d};
        if (s[Q_W+1:Q_W-1] == '0 || s[Q_W+1:Q_W-1] == '1) begin
            return t_q'(s[Q_W-1:0]);
        end
        return s[Q_W+1] ? Q_MIN : Q_MAX;
    endfunction

    // x faces: A*J*g11 / (J*dx*dx); y faces: A*J*g23*g23 / (g22*J*dy*dy)
    function automatic t_ops face_ops(input logic [CELL_W-1:0] c, input logic [CELL_W-1:0] n,
                                      input logic is_y);
        t_ops o;
        t_q   a_avg;
        t_q   j_avg;
        t_q   g23_avg;
        a_avg   = avg_q(cell_field(c, F_COEF), cell_field(n, F_COEF));
        j_avg   = avg_q(cell_field(c, F_JAC), cell_field(n, F_JAC));
        g23_avg = avg_q(cell_field(c, F_G23), cell_field(n, F_G23));
        o.diff   = diff_q(cell_field(n, F_VAL), cell_field(c, F_VAL));
        o.nop[0] = a_avg;
        o.nop[1] = j_avg;
        if (is_y) begin
            o.nop[2] = g23_avg;
            o.nop[3] = g23_avg;
            o.dop[0] = avg_q(cell_field(c, F_G22), cell_field(n, F_G22));
            o.dop[1] = cell_field(c, F_JAC);
            o.dop[2] = avg_q(cell_field(c, F_DY), cell_field(n, F_DY));
            o.dop[3] = cell_field(c, F_DY);
        end else begin
            o.nop[2] = avg_q(cell_field(c, F_G11), cell_field(n, F_G11));
            o.nop[3] = Q_ONE;
            o.dop[0] = cell_field(c, F_JAC);
            o.dop[1] = avg_q(cell_field(c, F_DX), cell_field(n, F_DX));
            o.dop[2] = cell_field(c, F_DX);
            o.dop[3] = Q_ONE;
        end
        return o;
    endfunction

    // fold operand i into the running products held in operand i
    function automatic t_ops chain_step(input t_ops s, input int i);
        t_ops o;
        o        = s;
        o.nop[i] = mul_q(t_q'(s.nop[i-1]), t_q'(s.nop[i]));
        o.dop[i] = mul_q(t_q'(s.dop[i-1]), t_q'(s.dop[i]));
        return o;
    endfunction

    function automatic t_div div_init(input t_ops s, input logic is_y);
        t_div           o;
        t_q             num;
        t_q             den;
        logic [Q_W-1:0] nmag;
        logic [Q_W-1:0] dmag;
        num  = is_y ? neg_q(t_q'(s.nop[NUM_OPS-1])) : t_q'(s.nop[NUM_OPS-1]);
        den  = t_q'(s.dop[NUM_OPS-1]);
        nmag = num[Q_W-1] ? Q_W'(-num) : Q_W'(num);
        dmag = den[Q_W-1] ? Q_W'(-den) : Q_W'(den);
        o.fault = (den == '0);
        o.neg   = num[Q_W-1] ^ den[Q_W-1];
        o.rem   = '0;
        o.sh    = {nmag, {FRAC_W{1'b0}}};
        o.dmag  = o.fault ? Q_W'(1) : dmag;
        o.diff  = s.diff;
        return o;
    endfunction

    function automatic t_div div_step(input t_div s);
        t_div         o;
        logic [Q_W:0] t;
        o    = s;
        t    = {s.rem, s.sh[QUO_W-1]};
        o.sh = {s.sh[QUO_W-2:0], 1'b0};
        if (t >= {1'b0, s.dmag}) begin
            o.rem   = Q_W'(t - {1'b0, s.dmag});
            o.sh[0] = 1'b1;
        end else begin
            o.rem = t[Q_W-1:0];
        end
        return o;
    endfunction

    // signed, saturated quotient; a zero divisor gives zero
    function automatic t_q div_coef(input t_div s);
        if (s.fault) begin
            return '0;
        end
        if (s.neg) begin
            return (s.sh > QUO_NEG_LIM) ? Q_MIN : t_q'(-s.sh[Q_W-1:0]);
        end
        return (s.sh > QUO_POS_LIM) ? Q_MAX : t_q'(s.sh[Q_W-1:0]);
    endfunction

endpackage

FILE: design/five_point_metric_laplacian_stencil_unit.sv
// Five-point variable-coefficient Laplacian over a streamed 2D grid.
// Input: s_axis carries one grid cell per transfer in row-major order, eight
// signed Q16.16 words (f, A, J, g11, g22, g23, dx, dy) from the lowest bit up.
// Output: m_axis carries one result per interior cell: value, row and column
// of the center cell in tdata, divide_fault in tuser, frame_last in tlast.
// The result for center (r-1, c) is computed when cell (r, c) is taken.
// Configuration: i_cfg_* writes row_length (index 0) or row_count (index 1),
// clamped to [3, max]; write only while the block is idle.
// Throughput: one cell per clock while s_axis_tready is high. The pipeline
// holds the 48 one-bit steps of the four face dividers and the three
// product stages.
// Two line buffers of MAX_ROW_LEN cells are block memories; the upper buffer
// is written in the cycle after each transfer.
// Reset (synchronous, active low) clears the row and column counters, the
// pipeline, output and skid valid bits; buffer contents are not cleared.
// Stall: an output register and one skid entry follow the pipeline, so a
// held result still lets s_axis take cells until the next result arrives;
// s_axis_tready drops only once the skid entry is full.
`include "assert_macros.svh"

module five_point_metric_laplacian_stencil_unit
    import fpml_pkg::*;
#(
    parameter int MAX_ROW_LEN = DEF_MAX_ROW_LEN,
    parameter int MAX_ROWS    = DEF_MAX_ROWS
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_W-1:0]      i_cfg_data,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // f, A, J, g11, g22, g23, dx, dy; 32 bits each
    input  logic [CELL_W-1:0]     s_axis_tdata,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // laplacian_value[31:0], center_row[41:32], center_col[51:42], zero pad
    output logic [OUT_DATA_W-1:0] m_axis_tdata,
    // divide_fault
    output logic                  m_axis_tuser,
    output logic                  m_axis_tlast
);

    localparam int CW    = $clog2(MAX_ROW_LEN);
    localparam int RW    = $clog2(MAX_ROWS);
    localparam int LW    = $clog2(MAX_ROW_LEN + 1);
    localparam int NW    = $clog2(MAX_ROWS + 1);
    localparam int LXW   = (LW > CFG_W) ? LW : CFG_W;
    localparam int NXW   = (NW > CFG_W) ? NW : CFG_W;
    localparam int CXW   = LW + 1;
    localparam int RXW   = NW + 1;
    localparam int LEN_RST = (ROW_LEN_RESET < MAX_ROW_LEN) ? ROW_LEN_RESET : MAX_ROW_LEN;
    localparam int CNT_RST = (ROW_CNT_RESET < MAX_ROWS) ? ROW_CNT_RESET : MAX_ROWS;
    localparam int ST_P  = 1 + NUM_OPS;
    localparam int NST   = ST_P + QUO_W + 4;
    localparam int PAD_W = OUT_DATA_W - Q_W - 2*POS_W;

    // control
    logic [CW-1:0] r_col;
    logic [RW-1:0] r_row;
    logic [LW-1:0] r_len;
    logic [NW-1:0] r_cnt;
    logic [LW-1:0] n_len;
    logic [NW-1:0] n_cnt;
    logic          r_wr_pend;
    logic [CW-1:0] r_wr_addr;
    logic [NST-1:0] r_vld;
    logic          r_skid_valid;
    logic          r_o_valid;
    logic          w_en;
    logic          w_accept;

    logic [CXW-1:0] w_col_x;
    logic [CXW-1:0] w_len_x;
    logic [RXW-1:0] w_row_x;
    logic [RXW-1:0] w_cnt_x;
    logic           w_interior;
    logic [CW-1:0]  w_right_addr;
    logic [LXW-1:0] w_cfg_lx;
    logic [NXW-1:0] w_cfg_nx;
    t_pos           n_pos;

    // line buffers
    logic [CELL_W-1:0] r_mem_center [MAX_ROW_LEN];
    logic [CELL_W-1:0] r_mem_upper  [MAX_ROW_LEN];

    // datapath
    logic [CELL_W-1:0] r_a_mid;
    logic [CELL_W-1:0] r_a_right;
    logic [CELL_W-1:0] r_a_up;
    logic [CELL_W-1:0] r_a_cur;
    logic [CELL_W-1:0] r_a_left;
    logic [CELL_W-1:0] w_nb [NUM_FACES];
    t_pos              r_pos  [NST];
    t_ops              r_ops  [NUM_OPS][NUM_FACES];
    t_div              r_div  [QUO_W+1][NUM_FACES];
    t_q                r_coef [NUM_FACES];
    t_q                r_q_diff [NUM_FACES];
    logic [NUM_FACES-1:0] r_q_fault;
    t_q                r_flux [NUM_FACES];
    logic [NUM_FACES-1:0] r_f_fault;
    t_q                r_s_lap;
    logic              r_s_fault;
    t_res              w_tail;
    t_res              r_o;
    t_res              r_skid;

    assign w_en          = !r_skid_valid;
    assign s_axis_tready = w_en;
    assign w_accept      = s_axis_tvalid && w_en;
    assign o_cfg_ready   = 1'b1;

    // position and stencil window
    assign w_col_x      = CXW'(r_col);
    assign w_len_x      = CXW'(r_len);
    assign w_row_x      = RXW'(r_row);
    assign w_cnt_x      = RXW'(r_cnt);
    assign w_right_addr = CW'(w_col_x + CXW'(1));
    assign w_interior   = (w_row_x >= RXW'(2)) && (w_row_x < w_cnt_x)
                       && (w_col_x >= CXW'(1)) && (w_col_x + CXW'(1) < w_len_x)
                       && (w_col_x < CXW'(MAX_ROW_LEN - 1));

    always_comb begin
        n_pos.row  = POS_W'(r_row - 1'b1);
        n_pos.col  = POS_W'(r_col);
        n_pos.last = (w_row_x + RXW'(1) == w_cnt_x) && (w_col_x + CXW'(2) == w_len_x);
    end

    // clamp configuration writes
    assign w_cfg_lx = LXW'(i_cfg_data);
    assign w_cfg_nx = NXW'(i_cfg_data);
    always_comb begin
        if (w_cfg_lx < LXW'(MIN_DIM)) begin
            n_len = LW'(MIN_DIM);
        end else if (w_cfg_lx > LXW'(MAX_ROW_LEN)) begin
            n_len = LW'(MAX_ROW_LEN);
        end else begin
            n_len = LW'(w_cfg_lx);
        end
        if (w_cfg_nx < NXW'(MIN_DIM)) begin
            n_cnt = NW'(MIN_DIM);
        end else if (w_cfg_nx > NXW'(MAX_ROWS)) begin
            n_cnt = NW'(MAX_ROWS);
        end else begin
            n_cnt = NW'(w_cfg_nx);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col     <= '0;
            r_row     <= '0;
            r_len     <= LW'(LEN_RST);
            r_cnt     <= NW'(CNT_RST);
            r_wr_pend <= 1'b0;
            r_vld     <= '0;
        end else begin
            if (i_cfg_valid) begin
                case (t_reg_idx'(i_cfg_index))
                    REG_ROW_LENGTH: r_len <= n_len;
                    REG_ROW_COUNT:  r_cnt <= n_cnt;
                    default: ;
                endcase
            end
            r_wr_pend <= w_accept;
            if (w_accept) begin
                if (w_col_x + CXW'(1) >= w_len_x) begin
                    r_col <= '0;
                    if (w_row_x + RXW'(1) >= w_cnt_x) begin
                        r_row <= '0;
                    end else begin
                        r_row <= RW'(w_row_x + RXW'(1));
                    end
                end else begin
                    r_col <= CW'(w_col_x + CXW'(1));
                end
            end
            if (w_en) begin
                r_vld <= {r_vld[NST-2:0], w_accept && w_interior};
            end
        end
    end

    // center buffer: read old contents, then store the new cell
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_mem_center[r_col] <= s_axis_tdata;
            r_a_mid             <= r_mem_center[r_col];
            r_a_right           <= r_mem_center[w_right_addr];
            r_a_cur             <= s_axis_tdata;
            // the left neighbor is the previous cell's center read
            r_a_left            <= r_a_mid;
            r_pos[0]            <= n_pos;
            r_wr_addr           <= r_col;
        end
    end

    // upper buffer: shift the old center row down in the cycle after the read
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_a_up <= r_mem_upper[r_col];
        end
        if (r_wr_pend) begin
            r_mem_upper[r_wr_addr] <= r_a_mid;
        end
    end

    assign w_nb[FACE_RIGHT] = r_a_right;
    assign w_nb[FACE_LEFT]  = r_a_left;
    assign w_nb[FACE_DOWN]  = r_a_cur;
    assign w_nb[FACE_UP]    = r_a_up;

    for (genvar p = 1; p < NST; p++) begin : g_pos
        always_ff @(posedge i_clk) begin
            if (w_en) begin
                r_pos[p] <= r_pos[p-1];
            end
        end
    end

    for (genvar k = 0; k < NUM_FACES; k++) begin : g_face
        localparam logic IS_Y = (k == FACE_DOWN) || (k == FACE_UP);

        always_ff @(posedge i_clk) begin
            if (w_en) begin
                r_ops[0][k] <= face_ops(r_a_mid, w_nb[k], IS_Y);
            end
        end

        for (genvar i = 1; i < NUM_OPS; i++) begin : g_mul
            always_ff @(posedge i_clk) begin
                if (w_en) begin
                    r_ops[i][k] <= chain_step(r_ops[i-1][k], i);
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (w_en) begin
                r_div[0][k] <= div_init(r_ops[NUM_OPS-1][k], IS_Y);
            end
        end

        for (genvar s = 0; s < QUO_W; s++) begin : g_div
            always_ff @(posedge i_clk) begin
                if (w_en) begin
                    r_div[s+1][k] <= div_step(r_div[s][k]);
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (w_en) begin
                r_coef[k]    <= div_coef(r_div[QUO_W][k]);
                r_q_diff[k]  <= t_q'(r_div[QUO_W][k].diff);
                r_q_fault[k] <= r_div[QUO_W][k].fault;
                r_flux[k]    <= mul_q(r_coef[k], r_q_diff[k]);
                r_f_fault[k] <= r_q_fault[k];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s_lap   <= sum4_q(r_flux[FACE_RIGHT], r_flux[FACE_LEFT],
                                r_flux[FACE_DOWN], r_flux[FACE_UP]);
            r_s_fault <= |r_f_fault;
        end
    end

    always_comb begin
        w_tail.lap   = r_s_lap;
        w_tail.pos   = r_pos[NST-1];
        w_tail.fault = r_s_fault;
    end

    // output register and skid entry
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid    <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (w_en) begin
            if (r_vld[NST-1]) begin
                if (!r_o_valid || m_axis_tready) begin
                    r_o_valid <= 1'b1;
                end else begin
                    r_skid_valid <= 1'b1;
                end
            end else if (m_axis_tready) begin
                r_o_valid <= 1'b0;
            end
        end else if (m_axis_tready) begin
            r_skid_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            if (r_vld[NST-1]) begin
                if (!r_o_valid || m_axis_tready) begin
                    r_o <= w_tail;
                end else begin
                    r_skid <= w_tail;
                end
            end
        end else if (m_axis_tready) begin
            r_o <= r_skid;
        end
    end

    assign m_axis_tvalid = r_o_valid;
    assign m_axis_tdata  = {{PAD_W{1'b0}}, r_o.pos.col, r_o.pos.row, r_o.lap};
    assign m_axis_tuser  = r_o.fault;
    assign m_axis_tlast  = r_o.pos.last;

    `FPML_ASSERT_IMP(a_skid_behind_out, r_skid_valid, r_o_valid,
        "skid entry holds a result while the output register is empty")
    `FPML_ASSERT_IMP(a_skid_fill, $rose(r_skid_valid), $past(r_o_valid && !m_axis_tready),
        "skid entry filled without a stalled output")
    `FPML_ASSERT_IMP(a_upper_wr_addr, r_wr_pend && w_accept, r_wr_addr != r_col,
        "delayed upper buffer write collides with the current read")

endmodule
